[rtl/bai_pkg.sv]
package bai_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = 21;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] ADDR_SRC_WIDTH  = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_SRC_HEIGHT = 4'h4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_ICON_SIZE  = 4'h8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_DIV_COL,
        ST_DIV_GRP,
        ST_OUT
    } state_t;

    // divider request and reply
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [SUM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SUM_W-1:0]  quotient;
    } div_rsp_t;

endpackage

[rtl/box_average_icon_downscaler.sv]
// Box-average icon downscaler: grey 8-bit source pixels enter in raster order on
// s_axis and an N by N icon leaves on m_axis, each icon pixel the truncated mean of
// per-column truncated means over its row group. Rows and columns are split into N
// groups of floor(size/N), the last size mod N groups one larger; N is icon_size
// clamped to 1..MAX_ICON and to the smaller source dimension. A pixel on a group's
// non-final row passes ram read, add and write back; on a group's final row it
// also waits for the column-mean division by the one shared radix-2 divider, and
// for a further group division when it closes a column group. The icon pixel sits
// in an output register, so a stalled m_axis holds back s_axis only once the next
// group division is done and waits for that register to empty. After reset, or a
// write to a size register, a clearing pass zeroes the column-sum ram and two size
// divisions follow before s_axis_tready rises; such a write restarts the frame.
module box_average_icon_downscaler
    import bai_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_ICON   = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // source pixels
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
    // icon pixels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] icon_pixel
    output logic                  m_axis_tlast    // icon_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CLR_W = COL_W + 1;

    logic [10:0] src_width_reg;
    logic [12:0] src_height_reg;
    logic [8:0]  icon_size_reg;
    logic        cfg_wr;

    // effective sizes, registered
    logic [SUM_W-1:0] w_eff, h_eff, n_eff, n_w;
    logic [SUM_W-1:0] w_reg, h_reg, n_reg;
    logic [SUM_W-1:0] rbase_reg, rext_reg, cbase_reg, cext_reg;

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [SUM_W-1:0] src_row_reg, src_row_next;
    logic [SUM_W-1:0] src_col_reg, src_col_next;
    logic [SUM_W-1:0] rg_reg, rg_next;
    logic [SUM_W-1:0] rig_reg, rig_next;
    logic [SUM_W-1:0] cg_reg, cg_next;
    logic [SUM_W-1:0] cig_reg, cig_next;
    logic [SUM_W-1:0] gsum_reg, gsum_next;
    logic [SUM_W-1:0] csum_reg, csum_next;
    logic [PIX_W-1:0] px_reg, px_next;
    logic             last_reg, last_next;
    logic [PIX_W-1:0] out_px_reg, out_px_next;
    logic             out_last_reg, out_last_next;
    logic             out_vld_reg, out_vld_next;
    logic [2:0]       prep_reg, prep_next;

    logic [SUM_W-1:0] rlen, clen;
    logic             we;
    logic [COL_W-1:0] waddr, raddr;
    logic [SUM_W-1:0] wdata, rdata;
    div_req_t         dreq;
    div_rsp_t         drsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 11'd64;
            src_height_reg <= 13'd64;
            icon_size_reg  <= 9'd16;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                ADDR_SRC_WIDTH:  src_width_reg  <= pwdata[10:0];
                ADDR_SRC_HEIGHT: src_height_reg <= pwdata[12:0];
                ADDR_ICON_SIZE:  icon_size_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_SRC_WIDTH:  prdata = {21'd0, src_width_reg};
            ADDR_SRC_HEIGHT: prdata = {19'd0, src_height_reg};
            ADDR_ICON_SIZE:  prdata = {23'd0, icon_size_reg};
            default:         prdata = '0;
        endcase
    end

    logic cfg_hit;
    assign cfg_hit = cfg_wr && (paddr == ADDR_SRC_WIDTH || paddr == ADDR_SRC_HEIGHT
                                || paddr == ADDR_ICON_SIZE);

    // clamp sizes
    always_comb
    begin
        w_eff = SUM_W'(src_width_reg);
        if (src_width_reg == '0) w_eff = SUM_W'(1);
        else if (w_eff > SUM_W'(MAX_WIDTH)) w_eff = SUM_W'(MAX_WIDTH);
        h_eff = SUM_W'(src_height_reg);
        if (src_height_reg == '0) h_eff = SUM_W'(1);
        else if (h_eff > SUM_W'(MAX_HEIGHT)) h_eff = SUM_W'(MAX_HEIGHT);
        n_eff = SUM_W'(icon_size_reg);
        if (icon_size_reg == '0) n_eff = SUM_W'(1);
        else if (n_eff > SUM_W'(MAX_ICON)) n_eff = SUM_W'(MAX_ICON);
        n_w = (n_eff > w_eff) ? w_eff : n_eff;
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_eff;
        h_reg <= h_eff;
        n_reg <= (n_w > h_eff) ? h_eff : n_w;
    end

    // group length: base + 1 for the last 'extra' groups
    assign rlen = rbase_reg + SUM_W'(rg_reg >= n_reg - rext_reg);
    assign clen = cbase_reg + SUM_W'(cg_reg >= n_reg - cext_reg);

    bai_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    bai_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        src_row_next  = src_row_reg;
        src_col_next  = src_col_reg;
        rg_next       = rg_reg;
        rig_next      = rig_reg;
        cg_next       = cg_reg;
        cig_next      = cig_reg;
        gsum_next     = gsum_reg;
        csum_next     = csum_reg;
        px_next       = px_reg;
        last_next     = last_reg;
        out_px_next   = out_px_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg;
        prep_next     = prep_reg;
        we            = 1'b0;
        waddr         = src_col_reg[COL_W-1:0];
        wdata         = '0;
        raddr         = src_col_reg[COL_W-1:0];
        dreq          = '0;
        s_axis_tready = 1'b0;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep zeros, then two divisions for the group bases
                we    = !clr_reg[CLR_W-1];
                waddr = clr_reg[COL_W-1:0];
                if (!clr_reg[CLR_W-1])
                begin
                    clr_next = clr_reg + 1'b1;
                end
                else if (!drsp.busy && !dreq.start)
                begin
                    case (prep_reg)
                        3'd0:
                        begin
                            dreq = '{start: 1'b1, dividend: h_reg, divisor: n_reg};
                            prep_next = 3'd1;
                        end
                        3'd1:
                        begin
                            if (drsp.done)
                            begin
                                dreq = '{start: 1'b1, dividend: w_reg, divisor: n_reg};
                                prep_next = 3'd2;
                            end
                        end
                        3'd2:
                        begin
                            if (drsp.done)
                            begin
                                prep_next = 3'd3;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    px_next    = s_axis_tdata;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                csum_next = rdata + SUM_W'(px_reg);
                we        = 1'b1;
                wdata     = csum_next;
                if (rig_reg + SUM_W'(1) >= rlen)
                begin
                    wdata      = '0;
                    dreq       = '{start: 1'b1, dividend: csum_next, divisor: rlen};
                    state_next = ST_DIV_COL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_COL:
            begin
                if (drsp.done)
                begin
                    gsum_next = gsum_reg + drsp.quotient;
                    cig_next  = cig_reg + SUM_W'(1);
                    if (cig_next >= clen)
                    begin
                        dreq       = '{start: 1'b1, dividend: gsum_next, divisor: clen};
                        last_next  = (rg_reg + SUM_W'(1) == n_reg)
                                     && (cg_reg + SUM_W'(1) == n_reg);
                        state_next = ST_DIV_GRP;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_GRP:
            begin
                // quotient stays put once the divider goes idle
                if (!drsp.busy && !out_vld_reg)
                begin
                    out_px_next   = drsp.quotient[PIX_W-1:0];
                    out_last_next = last_reg;
                    out_vld_next  = 1'b1;
                    gsum_next     = '0;
                    cig_next      = '0;
                    cg_next       = cg_reg + SUM_W'(1);
                    state_next    = ST_OUT;
                end
            end
            default:
            begin
                // ST_OUT: advance position; busy-free since result is registered
                state_next = ST_IDLE;
            end
        endcase

        // position update when a pixel retires
        if ((state_reg == ST_ACC && state_next == ST_IDLE) || state_reg == ST_OUT)
        begin
            src_col_next = src_col_reg + SUM_W'(1);
            if (src_col_next >= w_reg)
            begin
                src_col_next = '0;
                cg_next      = '0;
                cig_next     = '0;
                gsum_next    = '0;
                src_row_next = src_row_reg + SUM_W'(1);
                rig_next     = rig_reg + SUM_W'(1);
                if (rig_next >= rlen)
                begin
                    rig_next = '0;
                    rg_next  = rg_reg + SUM_W'(1);
                end
                if (src_row_next >= h_reg)
                begin
                    src_row_next = '0;
                    rg_next      = '0;
                    rig_next     = '0;
                end
            end
        end

        if (cfg_hit)
        begin
            state_next   = ST_CLEAR;
            clr_next     = '0;
            prep_next    = '0;
            src_row_next = '0;
            src_col_next = '0;
            rg_next      = '0;
            rig_next     = '0;
            cg_next      = '0;
            cig_next     = '0;
            gsum_next    = '0;
        end
    end

    // base and extra per dimension, extra = size - base * n
    logic [2*SUM_W-1:0] prod;
    assign prod = (prep_reg == 3'd2 ? rbase_reg : cbase_reg) * n_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR && prep_reg == 3'd1 && drsp.done)
        begin
            rbase_reg <= drsp.quotient;
        end
        if (state_reg == ST_CLEAR && prep_reg == 3'd2 && drsp.done)
        begin
            cbase_reg <= drsp.quotient;
            rext_reg  <= h_reg - prod[SUM_W-1:0];
        end
        if (state_reg == ST_CLEAR && prep_reg == 3'd3)
        begin
            cext_reg <= w_reg - prod[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            prep_reg     <= '0;
            src_row_reg  <= '0;
            src_col_reg  <= '0;
            rg_reg       <= '0;
            rig_reg      <= '0;
            cg_reg       <= '0;
            cig_reg      <= '0;
            gsum_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            prep_reg     <= prep_next;
            src_row_reg  <= src_row_next;
            src_col_reg  <= src_col_next;
            rg_reg       <= rg_next;
            rig_reg      <= rig_next;
            cg_reg       <= cg_next;
            cig_reg      <= cig_next;
            gsum_reg     <= gsum_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        csum_reg     <= csum_next;
        px_reg       <= px_next;
        last_reg     <= last_next;
        out_px_reg   <= out_px_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_px_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> src_col_reg < w_reg)
        else $error("column beyond width");
    a_result_only_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg) == ST_DIV_GRP)
        else $error("result not from group division");
`endif

endmodule

[rtl/bai_ram.sv]
module bai_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bai_div.sv]
module bai_div
    import bai_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   shifted;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SUM_W])
            begin
                rem_next = trial[SUM_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SUM_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg))
        else $error("divider done without busy");
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg || $past(req.start))
        else $error("divider still busy at done");
    a_count_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == CNT_W'(1)) |=> rsp.done)
        else $error("divider missed done");
`endif

endmodule
